@@ design/kabf_pkg.sv @@
// shared types and constants for the angle and bias kalman filter
`timescale 1ns / 1ps
package kabf_pkg;

    localparam int QSHIFT = 28;
    localparam int REG_W  = 31;
    localparam int IDX_W  = 8;
    localparam int WIDE_W = 40;

    localparam logic [REG_W-1:0] RST_Q_ANGLE = 31'd268435;
    localparam logic [REG_W-1:0] RST_Q_BIAS  = 31'd805306;
    localparam logic [REG_W-1:0] RST_R_MEAS  = 31'd8053064;
    localparam logic [REG_W-1:0] RST_DT      = 31'd2684355;

    // one in q4.28, turns the multiply-accumulate into a plain add
    localparam logic signed [31:0] Q_ONE = 32'sh1000_0000;

    localparam logic [IDX_W-1:0] REG_Q_ANGLE = 8'd0;
    localparam logic [IDX_W-1:0] REG_Q_BIAS  = 8'd1;
    localparam logic [IDX_W-1:0] REG_R_MEAS  = 8'd2;
    localparam logic [IDX_W-1:0] REG_DT      = 8'd3;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // operands of the shared unit: result = sat(c +/- round(a*b >> 28))
    typedef struct packed {
        logic signed [31:0]       a;
        logic signed [31:0]       b;
        logic signed [WIDE_W-1:0] c;
        logic                     neg;
    } t_mac_req;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic done;
    } t_div_sts;

endpackage

@@ design/kabf_if.sv @@
// handshake channel interfaces of the kalman filter
`timescale 1ns / 1ps
interface kabf_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] angle_in;
    logic signed [31:0] rate_in;
    modport source (output valid, cmd, angle_in, rate_in, input ready);
    modport sink   (input valid, cmd, angle_in, rate_in, output ready);
endinterface

interface kabf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] angle_out;
    logic signed [31:0] rate_out;
    modport source (output valid, angle_out, rate_out, input ready);
    modport sink   (input valid, angle_out, rate_out, output ready);
endinterface

interface kabf_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [30:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/kalman_angle_bias_filter.sv @@
// top level of the two-state angle and gyro bias kalman filter
// channels: i_in takes items (cmd, angle_in, rate_in), o_out gives one result
// (angle_out, rate_out) per item, i_cfg writes the four q4.28 registers
// (0 angle noise, 1 bias noise, 2 measurement noise, 3 time step); i_cfg is
// always ready and indexes above 3 are dropped.
// a load item goes straight to the result. an update item runs 15 steps
// through the one shared multiply-accumulate unit and two gain divisions
// in the serial divider.
// i_in is ready only while no item is in work, so one item is taken at a
// time; the result sits in an output register, and the next item is taken
// while it waits. if the receiver stalls, the following item finishes and
// then waits until the output register is free.
// reset (synchronous, active low) zeroes the angle, bias, rate and
// covariance and loads the default register values.
`timescale 1ns / 1ps
module kalman_angle_bias_filter (
    input logic         i_clk,
    input logic         i_rst_n,
    kabf_in_if.sink     i_in,
    kabf_out_if.source  o_out,
    kabf_cfg_if.sink    i_cfg
);
    import kabf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef enum logic [4:0] {
        ST_UR, ST_ANG, ST_INNER, ST_C00P, ST_C01P, ST_C10P, ST_C11P, ST_S,
        ST_K0, ST_K1, ST_Y, ST_ANGC, ST_BIAS, ST_C10U, ST_C11U, ST_C00U,
        ST_C01U
    } t_step;

    t_state r_state;
    t_step  r_step;

    logic [REG_W-1:0] r_qa, r_qb, r_rn, r_dt;
    logic signed [31:0] r_ang, r_bias, r_ur;
    logic signed [31:0] r_c00, r_c01, r_c10, r_c11;
    logic signed [31:0] r_inner, r_s, r_k0, r_k1, r_y;
    logic signed [31:0] r_meas, r_rate;
    logic               r_div_start;

    logic               r_out_valid;
    logic signed [31:0] r_out_angle, r_out_rate;

    t_mac_req           w_req;
    logic signed [31:0] w_sat;
    t_div_ctl           w_div_ctl;
    t_div_sts           w_div_sts;
    logic signed [31:0] w_q;
    logic signed [31:0] w_dt;

    assign w_dt = $signed({1'b0, r_dt});

    // operand select for the current step
    always_comb begin
        w_req = '{a: w_dt, b: Q_ONE, c: '0, neg: 1'b0};
        unique case (r_step)
            ST_UR:    w_req = '{a: r_bias, b: Q_ONE, c: WIDE_W'(r_rate), neg: 1'b1};
            ST_ANG:   w_req = '{a: w_dt, b: r_ur, c: WIDE_W'(r_ang), neg: 1'b0};
            ST_INNER: w_req = '{a: w_dt, b: r_c11,
                                c: $signed(WIDE_W'({1'b0, r_qa})) - WIDE_W'(r_c01)
                                   - WIDE_W'(r_c10),
                                neg: 1'b0};
            ST_C00P:  w_req = '{a: w_dt, b: r_inner, c: WIDE_W'(r_c00), neg: 1'b0};
            ST_C01P:  w_req = '{a: w_dt, b: r_c11, c: WIDE_W'(r_c01), neg: 1'b1};
            ST_C10P:  w_req = '{a: w_dt, b: r_c11, c: WIDE_W'(r_c10), neg: 1'b1};
            ST_C11P:  w_req = '{a: $signed({1'b0, r_qb}), b: w_dt,
                                c: WIDE_W'(r_c11), neg: 1'b0};
            ST_S:     w_req = '{a: $signed({1'b0, r_rn}), b: Q_ONE,
                                c: WIDE_W'(r_c00), neg: 1'b0};
            ST_Y:     w_req = '{a: r_ang, b: Q_ONE, c: WIDE_W'(r_meas), neg: 1'b1};
            ST_ANGC:  w_req = '{a: r_k0, b: r_y, c: WIDE_W'(r_ang), neg: 1'b0};
            ST_BIAS:  w_req = '{a: r_k1, b: r_y, c: WIDE_W'(r_bias), neg: 1'b0};
            ST_C10U:  w_req = '{a: r_k1, b: r_c00, c: WIDE_W'(r_c10), neg: 1'b1};
            ST_C11U:  w_req = '{a: r_k1, b: r_c01, c: WIDE_W'(r_c11), neg: 1'b1};
            ST_C00U:  w_req = '{a: r_k0, b: r_c00, c: WIDE_W'(r_c00), neg: 1'b1};
            ST_C01U:  w_req = '{a: r_k0, b: r_c01, c: WIDE_W'(r_c01), neg: 1'b1};
            default:  w_req = '{a: w_dt, b: Q_ONE, c: '0, neg: 1'b0};
        endcase
    end

    kabf_mac u_mac (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_sat (w_sat)
    );

    assign w_div_ctl.start = r_div_start;

    kabf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_p     ((r_step == ST_K0) ? r_c00 : r_c10),
        .i_s     (r_s),
        .o_sts   (w_div_sts),
        .o_q     (w_q)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.angle_out = r_out_angle;
    assign o_out.rate_out  = r_out_rate;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= RST_Q_ANGLE;
            r_qb <= RST_Q_BIAS;
            r_rn <= RST_R_MEAS;
            r_dt <= RST_DT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_Q_ANGLE: r_qa <= i_cfg.data;
                REG_Q_BIAS:  r_qb <= i_cfg.data;
                REG_R_MEAS:  r_rn <= i_cfg.data;
                REG_DT:      r_dt <= i_cfg.data;
                default:     ;
            endcase
        end
    end

    // sequencer and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_UR;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_ang       <= '0;
            r_bias      <= '0;
            r_ur        <= '0;
            r_c00       <= '0;
            r_c01       <= '0;
            r_c10       <= '0;
            r_c11       <= '0;
        end else begin
            r_div_start <= 1'b0;
            // a finishing item refills the output register in S_DONE instead
            if (o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.cmd == CMD_LOAD) begin
                            r_ang   <= i_in.angle_in;
                            r_state <= S_DONE;
                        end else begin
                            r_meas  <= i_in.angle_in;
                            r_rate  <= i_in.rate_in;
                            r_step  <= ST_UR;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    case (r_step)
                        ST_UR:    r_ur    <= w_sat;
                        ST_ANG:   r_ang   <= w_sat;
                        ST_INNER: r_inner <= w_sat;
                        ST_C00P:  r_c00   <= w_sat;
                        ST_C01P:  r_c01   <= w_sat;
                        ST_C10P:  r_c10   <= w_sat;
                        ST_C11P:  r_c11   <= w_sat;
                        ST_S:     r_s     <= w_sat;
                        ST_Y:     r_y     <= w_sat;
                        ST_ANGC:  r_ang   <= w_sat;
                        ST_BIAS:  r_bias  <= w_sat;
                        ST_C10U:  r_c10   <= w_sat;
                        ST_C11U:  r_c11   <= w_sat;
                        ST_C00U:  r_c00   <= w_sat;
                        ST_C01U:  r_c01   <= w_sat;
                        default:  ;
                    endcase
                    r_step <= t_step'(r_step + 5'd1);
                    if (r_step == ST_C01U) begin
                        r_state <= S_DONE;
                    end else if (r_step == ST_S) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_DIV: begin
                    if (w_div_sts.done) begin
                        if (r_step == ST_K0) begin
                            r_k0        <= w_q;
                            r_step      <= ST_K1;
                            r_div_start <= 1'b1;
                        end else begin
                            r_k1    <= w_q;
                            r_step  <= ST_Y;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_angle <= r_ang;
                        r_out_rate  <= r_ur;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.cmd == CMD_LOAD) |=> (r_state == S_DONE))
        else $error("load item did not go straight to result");

    a_update_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.cmd == CMD_UPDATE)
        |=> (r_state == S_MUL && r_step == ST_UR))
        else $error("update item did not start the step sequence");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_DONE))
        else $error("result shown without finishing an item");

    a_div_in_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == S_DIV && (r_step == ST_K0 || r_step == ST_K1)))
        else $error("divider started outside the gain steps");
`endif

endmodule

@@ design/kabf_mac.sv @@
// shared multiply, round, accumulate and saturate unit
`timescale 1ns / 1ps
module kabf_mac (
    input  logic                i_clk,
    input  kabf_pkg::t_mac_req  i_req,
    output logic signed [31:0]  o_sat
);
    import kabf_pkg::*;

    logic signed [63:0]       r_prod;
    logic signed [63:0]       w_rnd;
    logic signed [WIDE_W-1:0] w_term;
    logic signed [WIDE_W-1:0] w_sum;

    // the product is registered; round, add and saturate are combinational
    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end

    // rounded product stays within 36 bits, so a signed cut to the wide width keeps it
    assign w_rnd  = (r_prod + (64'sd1 <<< (QSHIFT - 1))) >>> QSHIFT;
    assign w_term = i_req.neg ? -WIDE_W'(w_rnd) : WIDE_W'(w_rnd);
    assign w_sum  = i_req.c + w_term;

    always_comb begin
        if (w_sum[WIDE_W-1:31] == '0 || w_sum[WIDE_W-1:31] == '1) begin
            o_sat = w_sum[31:0];
        end else if (w_sum[WIDE_W-1]) begin
            o_sat = 32'sh8000_0000;
        end else begin
            o_sat = 32'sh7fff_ffff;
        end
    end

endmodule

@@ design/kabf_div.sv @@
// serial divider for the gains: sat((p << 28) / s), truncated toward zero, 0 when s is 0
`timescale 1ns / 1ps
module kabf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kabf_pkg::t_div_ctl i_ctl,
    input  logic signed [31:0] i_p,
    input  logic signed [31:0] i_s,
    output kabf_pkg::t_div_sts o_sts,
    output logic signed [31:0] o_q
);
    import kabf_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_dlo;
    logic [31:0] r_quo;
    logic [31:0] r_sm;
    logic        r_neg;
    logic signed [31:0] r_q;

    logic [31:0] w_pm;
    logic [31:0] w_sm;
    logic [32:0] w_trial;
    logic        w_qbit;
    logic [31:0] n_quo;

    assign w_pm    = i_p[31] ? 32'(-i_p) : 32'(i_p);
    assign w_sm    = i_s[31] ? 32'(-i_s) : 32'(i_s);
    assign w_trial = {r_rem, r_dlo[31]};
    assign w_qbit  = (w_trial >= {1'b0, r_sm});
    assign n_quo   = {r_quo[30:0], w_qbit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_neg <= i_p[31] ^ i_s[31];
                r_sm  <= w_sm;
                if (i_s == 32'sd0) begin
                    r_q    <= 32'sd0;
                    r_done <= 1'b1;
                end else if ({3'b0, w_pm} >= {w_sm, 3'b0}) begin
                    // quotient magnitude reaches 2^31: saturate
                    r_q    <= (i_p[31] ^ i_s[31]) ? 32'sh8000_0000 : 32'sh7fff_ffff;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= {4'b0, w_pm[31:4]};
                    r_dlo  <= {w_pm[3:0], 28'b0};
                    r_quo  <= '0;
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                // remainder stays below the divisor, so 32 bits hold it
                r_rem <= w_qbit ? 32'(w_trial - {1'b0, r_sm}) : w_trial[31:0];
                r_dlo <= {r_dlo[30:0], 1'b0};
                r_quo <= n_quo;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_q    <= r_neg ? -$signed(n_quo) : $signed(n_quo);
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_q        = r_q;

endmodule

@@ tb/kabf_test_if.sv @@
// clock constant of the kalman filter testbench
`timescale 1ns / 1ps
package kabf_test_pkg;
    localparam int TB_CLK_HALF = 5;
endpackage

@@ tb/kalman_angle_bias_filter_test.sv @@
// testbench for the angle and bias kalman filter: a fixed point predictor checks every result
`timescale 1ns / 1ps
module kalman_angle_bias_filter_test;
    import kabf_pkg::*;
    import kabf_test_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kabf_in_if  in_ch();
    kabf_out_if out_ch();
    kabf_cfg_if cfg_ch();

    kalman_angle_bias_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    always begin
        #TB_CLK_HALF i_clk = 1'b1;
        #TB_CLK_HALF i_clk = 1'b0;
    end

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } t_filter_out;

    // predictor copy of the filter
    logic [REG_W-1:0] reg_qa, reg_qb, reg_r, reg_dt;
    longint p_angle, p_bias, p_rate, p00, p01, p10, p11;
    t_filter_out expected_outputs[$];

    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    longint cycles = 0;

    function automatic longint sat(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< 27);
        return p >>> 28;
    endfunction

    function automatic longint gain_of(longint p, longint s);
        if (s == 0) return 0;
        return sat((p * (64'sd1 <<< 28)) / s);
    endfunction

    task automatic predictor_reset();
        reg_qa = RST_Q_ANGLE; reg_qb = RST_Q_BIAS; reg_r = RST_R_MEAS; reg_dt = RST_DT;
        p_angle = 0; p_bias = 0; p_rate = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
    endtask

    task automatic predict_filter(logic cmd, logic signed [31:0] meas, logic signed [31:0] rt);
        longint dt, inner, s, k0, k1, y, c00, c01;
        t_filter_out e;
        if (cmd == CMD_LOAD) begin
            p_angle = longint'(meas);
        end else begin
            dt = longint'(reg_dt);
            p_rate = sat(longint'(rt) - p_bias);
            p_angle = sat(p_angle + qmul(dt, p_rate));
            inner = sat(qmul(dt, p11) - p01 - p10 + longint'(reg_qa));
            p00 = sat(p00 + qmul(dt, inner));
            p01 = sat(p01 - qmul(dt, p11));
            p10 = sat(p10 - qmul(dt, p11));
            p11 = sat(p11 + qmul(longint'(reg_qb), dt));
            s = sat(p00 + longint'(reg_r));
            k0 = gain_of(p00, s);
            k1 = gain_of(p10, s);
            y = sat(longint'(meas) - p_angle);
            p_angle = sat(p_angle + qmul(k0, y));
            p_bias = sat(p_bias + qmul(k1, y));
            c00 = p00;
            c01 = p01;
            p00 = sat(p00 - qmul(k0, c00));
            p01 = sat(p01 - qmul(k0, c01));
            p10 = sat(p10 - qmul(k1, c00));
            p11 = sat(p11 - qmul(k1, c01));
        end
        e.angle = p_angle[31:0];
        e.rate = p_rate[31:0];
        expected_outputs.push_back(e);
    endtask

    initial begin
        in_ch.valid = 1'b0; in_ch.cmd = 1'b0; in_ch.angle_in = '0; in_ch.rate_in = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    end

    // receiver side with random stalls, and a timeout that ends the test
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000) begin
            $display("end of test: mismatches");
            $finish;
        end
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_filter_out e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %h",
                    out_ch.angle_out, out_ch.rate_out);
            end else begin
                e = expected_outputs.pop_front();
                if (e.angle !== out_ch.angle_out || e.rate !== out_ch.rate_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp angle %h rate %h, got angle %h rate %h",
                            e.angle, e.rate, out_ch.angle_out, out_ch.rate_out);
                end
            end
        end
    end

    // valid stays up after a transfer until the next item or an idle cycle replaces it
    task automatic send_item(logic cmd, logic signed [31:0] meas, logic signed [31:0] rt);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1; in_ch.cmd <= cmd; in_ch.angle_in <= meas; in_ch.rate_in <= rt;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_filter(cmd, meas, rt);
    endtask

    task automatic write_register(logic [7:0] idx, logic [30:0] val);
        cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_Q_ANGLE: reg_qa = val;
            REG_Q_BIAS:  reg_qb = val;
            REG_R_MEAS:  reg_r = val;
            REG_DT:      reg_dt = val;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic random_update_run(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                send_item(CMD_LOAD, $urandom, $urandom);
            else if ($urandom_range(9) == 0)
                send_item(CMD_UPDATE, $urandom, $urandom);
            else
                send_item(CMD_UPDATE, $urandom_range(3000000) - 1500000,
                    $urandom_range(200000) - 100000);
        end
        wait_drained();
    endtask

    task automatic test_directed_extremes();
        send_item(CMD_UPDATE, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_item(CMD_UPDATE, 32'sh8000_0000, 32'sh8000_0000);
        send_item(CMD_LOAD, 32'sh7fff_ffff, 32'sh8000_0000);
        send_item(CMD_UPDATE, 0, 0);
        send_item(CMD_LOAD, 32'sh8000_0000, 32'sh7fff_ffff);
        send_item(CMD_UPDATE, 32'sh0001_0000, -32'sh0001_0000);
        send_item(CMD_LOAD, 0, 0);
        send_item(CMD_UPDATE, -32'sh0100_0000, 32'sh0010_0000);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        // zero measurement noise and zero dt, then all-ones registers, then one-lsb noise and dt
        write_register(REG_R_MEAS, '0);
        write_register(REG_DT, '0);
        write_register(8'd200, 31'h7fff_ffff);
        send_item(CMD_UPDATE, 32'sh0001_0000, 32'sh0002_0000);
        send_item(CMD_UPDATE, 0, 0);
        wait_drained();
        write_register(REG_Q_ANGLE, 31'h7fff_ffff);
        write_register(REG_Q_BIAS, 31'h7fff_ffff);
        write_register(REG_R_MEAS, 31'h7fff_ffff);
        write_register(REG_DT, 31'h7fff_ffff);
        for (int i = 0; i < 6; i++) send_item(CMD_UPDATE, $urandom, $urandom);
        wait_drained();
        write_register(REG_R_MEAS, 31'd1);
        write_register(REG_DT, 31'd1);
        write_register(REG_Q_ANGLE, '0);
        write_register(REG_Q_BIAS, '0);
        for (int i = 0; i < 6; i++) send_item(CMD_UPDATE, $urandom, $urandom);
        wait_drained();
    endtask

    task automatic test_random_settings();
        write_register(REG_Q_ANGLE, RST_Q_ANGLE);
        write_register(REG_Q_BIAS, RST_Q_BIAS);
        write_register(REG_R_MEAS, RST_R_MEAS);
        write_register(REG_DT, RST_DT);
        send_idle_pct = 16; recv_idle_pct = 76;
        random_update_run(250);
        write_register(REG_Q_ANGLE, 31'($urandom_range(2000000)));
        write_register(REG_Q_BIAS, 31'($urandom_range(2000000)));
        write_register(REG_R_MEAS, 31'($urandom_range(50000000, 1)));
        write_register(REG_DT, 31'($urandom_range(30000000, 1)));
        send_idle_pct = 76; recv_idle_pct = 16;
        random_update_run(250);
        write_register(REG_Q_ANGLE, 31'($urandom));
        write_register(REG_DT, 31'($urandom_range(5000000, 1)));
        send_idle_pct = 0; recv_idle_pct = 0;
        random_update_run(280);
    endtask

    initial begin
        predictor_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_register_extremes();
        test_random_settings();
        if (mismatches == 0 && expected_outputs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ files.f @@
design/kabf_pkg.sv
design/kabf_if.sv
design/kabf_mac.sv
design/kabf_div.sv
design/kalman_angle_bias_filter.sv
tb/kabf_test_if.sv
tb/kalman_angle_bias_filter_test.sv
